// File: hw/rtl/bdasc_pkg.sv
package bdasc_pkg;

   // Default widths and depths.
   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_DIGITS_DEF = 10;
   localparam int QUEUE_DEPTH    = 2;

   // Character and digit formats.
   localparam int          DIGIT_BITS = 4;
   localparam int          CHAR_BITS  = 6;
   localparam logic [5:0]  ASCII_ZERO = 6'd48;
   localparam logic [5:0]  ASCII_NINE = 6'd57;

   // Control that travels with an item from the queue to the converter.
   typedef struct packed {
      logic valid;
      logic zero;
   } q_ctl_type;

   // Converter sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// File: hw/rtl/bdasc_if.sv
// Input channel: one binary number per item.
interface bdasc_req_if #(parameter int VALUE_BITS = bdasc_pkg::VALUE_BITS_DEF);
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

// Result channel: one ASCII digit per item.
interface bdasc_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] digit_char;
   logic       last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// File: hw/rtl/bdasc_front.sv
module bdasc_front #(
   parameter int VALUE_BITS = bdasc_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   bdasc_req_if.sink             req,
   output bdasc_pkg::q_ctl_type  q_ctl,
   output logic [VALUE_BITS-1:0] q_value,
   input  logic                  q_ready
);
   import bdasc_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [VALUE_BITS-1:0] value_ff [QUEUE_DEPTH];
   logic                  zero_ff  [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  push;
   logic                  pop;

   // Handshakes on both sides of the queue.
   assign req.ready   = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign push        = req.valid && req.ready;
   assign q_ctl.valid = (count_ff != '0);
   assign q_ctl.zero  = zero_ff[rd_ptr_ff];
   assign q_value     = value_ff[rd_ptr_ff];
   assign pop         = q_ctl.valid && q_ready;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage; a zero input is marked so the converter can skip its shift phase.
   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= req.value;
         zero_ff[wr_ptr_ff]  <= (req.value == '0);
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue fill count out of range");

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on a push");

   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count did not shrink on a pop");

endmodule

// File: hw/rtl/bdasc_back.sv
module bdasc_back #(
   parameter int VALUE_BITS = bdasc_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = bdasc_pkg::MAX_DIGITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bdasc_pkg::q_ctl_type  q_ctl,
   input  logic [VALUE_BITS-1:0] q_value,
   output logic                  q_ready,
   bdasc_rsp_if.source           rsp
);
   import bdasc_pkg::*;

   localparam int BCD_BITS  = DIGIT_BITS * MAX_DIGITS;
   localparam int BCNT_BITS = $clog2(VALUE_BITS + 1);
   localparam int DCNT_BITS = $clog2(MAX_DIGITS + 1);

   state_type              state_ff, state_in;
   logic [VALUE_BITS-1:0]  shift_ff, shift_in;
   logic [BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [BCNT_BITS-1:0]   bcnt_ff, bcnt_in;
   logic [DCNT_BITS-1:0]   dcnt_ff, dcnt_in;
   logic                   ovf_ff, ovf_in;
   logic                   started_ff, started_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CHAR_BITS-1:0]   char_ff, char_in;
   logic                   last_ff, last_in;
   logic [BCD_BITS-1:0]    adj;
   logic [BCD_BITS-1:0]    dab_next;
   logic                   dab_carry;
   logic [DIGIT_BITS-1:0]  top_digit;
   logic                   out_free;
   logic                   skip;

   // One double-dabble step: correct each digit, then shift in the next value bit.
   always_comb begin
      adj = bcd_ff;
      for (int i = 0; i < MAX_DIGITS; i++) begin
         if (bcd_ff[DIGIT_BITS*i +: DIGIT_BITS] >= 4'd5) begin
            adj[DIGIT_BITS*i +: DIGIT_BITS] = bcd_ff[DIGIT_BITS*i +: DIGIT_BITS] + 4'd3;
         end
      end
      dab_next  = {adj[BCD_BITS-2:0], shift_ff[VALUE_BITS-1]};
      dab_carry = adj[BCD_BITS-1];
   end

   // Digit emission looks at the top digit and shifts the window left.
   assign top_digit = bcd_ff[BCD_BITS-1 -: DIGIT_BITS];
   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign skip      = !started_ff && (top_digit == '0) && (dcnt_ff != DCNT_BITS'(1)) && !ovf_ff;
   assign q_ready   = (state_ff == ST_IDLE);

   // Sequencer: take an item, convert it bit by bit, then emit digits.
   always_comb begin
      state_in     = state_ff;
      shift_in     = shift_ff;
      bcd_in       = bcd_ff;
      bcnt_in      = bcnt_ff;
      dcnt_in      = dcnt_ff;
      ovf_in       = ovf_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      char_in      = char_ff;
      last_in      = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_ctl.valid) begin
               shift_in   = q_value;
               bcd_in     = '0;
               bcnt_in    = BCNT_BITS'(VALUE_BITS);
               dcnt_in    = DCNT_BITS'(MAX_DIGITS);
               ovf_in     = 1'b0;
               started_in = 1'b0;
               state_in   = q_ctl.zero ? ST_EMIT : ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in   = dab_next;
            ovf_in   = ovf_ff || dab_carry;
            shift_in = shift_ff << 1;
            bcnt_in  = bcnt_ff - 1'b1;
            if (bcnt_ff == BCNT_BITS'(1)) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               bcd_in  = {bcd_ff[BCD_BITS-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
               dcnt_in = dcnt_ff - 1'b1;
               if (!skip) begin
                  rsp_valid_in = 1'b1;
                  char_in      = ASCII_ZERO + CHAR_BITS'(top_digit);
                  last_in      = (dcnt_ff == DCNT_BITS'(1));
                  started_in   = 1'b1;
               end
               if (dcnt_ff == DCNT_BITS'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         ovf_ff       <= 1'b0;
         bcnt_ff      <= '0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         ovf_ff       <= ovf_in;
         bcnt_ff      <= bcnt_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.digit_char = char_ff;
   assign rsp.last_digit = last_ff;

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (char_ff >= ASCII_ZERO) && (char_ff <= ASCII_NINE))
      else $error("emitted character is not a decimal digit");

   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CONV |-> bcnt_ff != '0)
      else $error("conversion running with no bits left");

   a_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && dcnt_ff == DCNT_BITS'(1)
      |=> rsp_valid_ff && last_ff && state_ff == ST_IDLE)
      else $error("run did not end with a flagged last digit");

   a_ovf_no_skip: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && out_free && ovf_ff |=> rsp_valid_ff)
      else $error("digit skipped in a full-width window");

endmodule

// File: hw/rtl/binary_to_decimal_ascii.sv
// Converts one unsigned binary number per input item into its decimal digits as ASCII
// characters, most significant first, without leading zeros; zero gives a single '0' and
// the final digit of each run carries last_digit. A two-entry queue takes items while the
// converter is busy. Per item the converter takes it from the queue, shifts it through
// double-dabble bit by bit (skipped for a zero input), and walks the decimal window from
// the top, one digit position a cycle while the result side is free.
// Numbers with more than MAX_DIGITS digits give their low MAX_DIGITS digits, zeros kept.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = bdasc_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = bdasc_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   bdasc_req_if.sink   req,
   bdasc_rsp_if.source rsp
);
   import bdasc_pkg::*;

   q_ctl_type             q_ctl;
   logic [VALUE_BITS-1:0] q_value;
   logic                  q_ready;

   // Front end: input queue and zero detection.
   bdasc_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .q_ctl   (q_ctl),
      .q_value (q_value),
      .q_ready (q_ready)
   );

   // Back end: bit-serial conversion and digit emission.
   bdasc_back #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .q_ctl   (q_ctl),
      .q_value (q_value),
      .q_ready (q_ready),
      .rsp     (rsp)
   );

endmodule

// File: tb/tb_binary_to_decimal_ascii.sv
module tb_binary_to_decimal_ascii;
   timeunit 1ns;
   timeprecision 1ps;

   import bdasc_pkg::*;

   localparam int VALUE_BITS   = VALUE_BITS_DEF;
   localparam int MAX_DIGITS   = MAX_DIGITS_DEF;
   localparam int RADIX        = 10;
   localparam int IDLE_PCT     = 12;
   localparam int RANDOM_ITEMS = 104;
   // Allow a margin after the last digit.
   localparam int DRAIN_CYCLES = 2 * (1 + VALUE_BITS + MAX_DIGITS);
   localparam int SETTLE_LIMIT = 50000;

   // One expected character of a decimal run.
   typedef struct {
      logic [CHAR_BITS-1:0] digit_char;
      logic                 last_digit;
   } digit_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdasc_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   bdasc_rsp_if                            rsp_ch ();

   binary_to_decimal_ascii #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS)
   ) i_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   logic [VALUE_BITS-1:0] pending_values[$];
   digit_entry_type       expected_chars[$];
   int                    error_count  = 0;
   int                    items_taken  = 0;
   bit                    req_taken    = 1'b0;
   logic                  steady;

   // A stretch of the run in which neither side idles.
   assign steady = (items_taken >= 50) && (items_taken < 85);

   always #6 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Splits a number into its decimal characters, most significant first, and queues them.
   function automatic void push_decimal_chars(input logic [VALUE_BITS-1:0] value);
      logic [DIGIT_BITS-1:0] digits[MAX_DIGITS];
      logic [VALUE_BITS-1:0] rest;
      digit_entry_type       entry;
      int                    count;
      rest = value;
      for (count = 0; count == 0 || (rest != 0 && count < MAX_DIGITS); count++) begin
         digits[count] = DIGIT_BITS'(rest % RADIX);
         rest          = rest / RADIX;
      end
      for (int k = count - 1; k >= 0; k--) begin
         entry.digit_char = ASCII_ZERO + CHAR_BITS'(digits[k]);
         entry.last_digit = (k == 0);
         expected_chars.push_back(entry);
      end
   endfunction

   // Driver: presents the next pending number once the current one has been taken.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= '0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_values.size() != 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
            req_ch.valid <= 1'b1;
            req_ch.value <= pending_values.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // The result side stalls at random outside the steady stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   // Monitor: predicts on each accepted number and checks each accepted character.
   always @(posedge clock) begin
      digit_entry_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            items_taken++;
            push_decimal_chars(req_ch.value);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%0h last=%0b",
                                         rsp_ch.digit_char, rsp_ch.last_digit));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ch.digit_char !== want.digit_char) begin
                  report_mismatch($sformatf("digit_char 0x%0h, wanted 0x%0h",
                                            rsp_ch.digit_char, want.digit_char));
               end
               if (rsp_ch.last_digit !== want.last_digit) begin
                  report_mismatch($sformatf("last_digit %0b, wanted %0b",
                                            rsp_ch.last_digit, want.last_digit));
               end
            end
         end
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [VALUE_BITS-1:0] pow10[MAX_DIGITS];
      logic [VALUE_BITS-1:0] value;
      int                    k;
      int                    waited;

      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;

      pow10[0] = 1;
      for (int i = 1; i < MAX_DIGITS; i++) begin
         pow10[i] = pow10[i-1] * RADIX;
      end

      // Directed numbers: zero, single digits, digit-count boundaries and the full range.
      pending_values.push_back(32'd0);
      pending_values.push_back(32'd1);
      pending_values.push_back(32'd9);
      pending_values.push_back(32'd10);
      pending_values.push_back(32'd99);
      pending_values.push_back(32'd100);
      pending_values.push_back(32'd1000000);
      pending_values.push_back(32'd999999999);
      pending_values.push_back(32'd1000000000);
      pending_values.push_back(32'd1234567890);
      pending_values.push_back(32'd987654321);
      pending_values.push_back(32'h8000_0000);
      pending_values.push_back(32'h5555_5555);
      pending_values.push_back(32'hAAAA_AAAA);
      pending_values.push_back(32'hFFFF_FFFF);
      pending_values.push_back(32'd0);

      // Random numbers spread over all digit counts, with extra weight near powers of ten.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         case ($urandom_range(0, 4))
            0, 1: begin
               value = $urandom();
            end
            2, 3: begin
               value = $urandom() >> $urandom_range(0, VALUE_BITS - 1);
            end
            default: begin
               k     = $urandom_range(0, MAX_DIGITS - 1);
               value = pow10[k] + $urandom_range(0, 2) - 1;
            end
         endcase
         pending_values.push_back(value);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_ch.valid) @(posedge clock);
      waited = 0;
      while (expected_chars.size() != 0 && waited < SETTLE_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (expected_chars.size() != 0) begin
         report_mismatch($sformatf("%0d characters never arrived", expected_chars.size()));
      end

      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
